// ===== rtl/core/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg
// Types, codes and helpers shared by the sorted timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package stq_pkg;

   // request kinds
   localparam logic [1:0] FUNC_CREATE = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_UPDATE = 2'd2;

   // result status codes
   localparam logic [2:0] ST_CREATED   = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FIRED     = 3'd4;
   localparam logic [2:0] ST_NONE_DUE  = 3'd5;

   // register indexes
   localparam logic REG_DELAY_FLOOR = 1'b0;
   localparam logic REG_MAX_FIRES   = 1'b1;

   localparam logic [6:0] MAX_RESULTS = 7'd64;

   // one table entry as stored in memory
   typedef struct packed {
      logic [31:0] id;
      logic [47:0] deadline;
      logic [31:0] period;
      logic        once;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_RM_RD,
      S_RM_CHK,
      S_UPD_RD,
      S_UPD_CHK,
      S_UPD_END
   } state_type;

   // 48-bit add that saturates at all ones
   function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
      logic [48:0] sum;
      sum = {1'b0, a} + {17'b0, b};
      return sum[48] ? {48{1'b1}} : sum[47:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sorted_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer table kept ordered by deadline in one RAM, earliest at the top.
// ----------------------------------------------------------------------------
// Usage: drive the req_ fields with start high while busy is low; the item
// is taken at that edge. Results appear on rsp_status / rsp_timer_id /
// rsp_last for one cycle each, marked by rsp_valid; rsp_last flags the final
// result of an item. The receiver cannot stall, so results are never held.
// Create reads entry by entry down from the top of the table while sliding
// toward its slot; remove scans the whole table; update handles each fired
// timer in turn plus the reinsert of each periodic one, then gives its final
// result. A full-table create and a remove of ID 0 answer in the cycle after
// the item is taken, with no table access. The cost is set by the
// single-read-port table RAM: each entry is read, then compared and written
// back. Items are handled one at a time. Configuration (delay floor at 0x0,
// max_fires at 0x4) is to be written over the APB-style port only while
// idle; the block does not enforce this. Reset empties the table, zeroes the
// ID counter and loads a delay floor of 1 and max_fires = 64; table contents
// are not cleared, only entries below the live count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_func,
   input  wire logic [47:0] req_time_now,
   input  wire logic [31:0] req_timeout,
   input  wire logic        req_one_shot,
   input  wire logic [31:0] req_target_id,
   // result channel
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_timer_id,
   output logic             rsp_last,
   // configuration port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $bits(entry_type);

   state_type   state_ff, state_in;
   logic [CW-1:0] live_ff, live_in;
   logic [CW-1:0] hole_ff, hole_in;
   logic [31:0] idc_ff, idc_in;
   logic [31:0] mind_ff, mind_in;
   logic [6:0]  maxf_ff, maxf_in;
   logic        found_ff, found_in;
   logic        retu_ff, retu_in;
   entry_type   new_ff, new_in;
   logic [47:0] now_ff, now_in;
   logic [31:0] tgt_ff, tgt_in;
   logic [6:0]  nfire_ff, nfire_in;
   logic [6:0]  limit_ff, limit_in;
   logic        pend_ff, pend_in;
   logic [31:0] pid_ff, pid_in;
   logic        rv_ff, rv_in;
   logic [2:0]  rs_ff, rs_in;
   logic [31:0] rid_ff, rid_in;
   logic        rl_ff, rl_in;

   logic          accept, csr_wr;
   logic          we;
   logic [AW-1:0] waddr, raddr;
   entry_type     wdata, rd;
   logic [EW-1:0] rdata;
   logic [CW-1:0] hole_m1, live_m1;
   logic [31:0]   to_eff;

   assign accept  = start && (state_ff == S_IDLE);
   assign csr_wr  = psel && penable && pwrite && pready;
   assign busy    = (state_ff != S_IDLE);
   assign hole_m1 = hole_ff - CW'(1);
   assign live_m1 = live_ff - CW'(1);
   assign rd      = entry_type'(rdata);
   assign to_eff  = (req_timeout < mind_ff) ? mind_ff : req_timeout;

   // table memory
   stq_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (EW'(wdata)),
      .raddr (raddr),
      .rdata (rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  FUNC_CREATE: if (live_ff != CW'(SLOTS)) state_in = S_INS_RD;
                  FUNC_REMOVE: if (req_target_id != 32'd0) state_in = S_RM_RD;
                  FUNC_UPDATE: state_in = S_UPD_RD;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_INS_RD: begin
            if (hole_ff == '0) state_in = retu_ff ? S_UPD_RD : S_IDLE;
            else               state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (rd.deadline > new_ff.deadline) state_in = retu_ff ? S_UPD_RD : S_IDLE;
            else                               state_in = S_INS_RD;
         end
         S_RM_RD:  state_in = (hole_ff == live_ff) ? S_IDLE : S_RM_CHK;
         S_RM_CHK: state_in = S_RM_RD;
         S_UPD_RD: begin
            if (nfire_ff == limit_ff || live_ff == '0) state_in = S_UPD_END;
            else                                       state_in = S_UPD_CHK;
         end
         S_UPD_CHK: begin
            if (rd.deadline > now_ff) state_in = S_UPD_END;
            else if (!rd.once)        state_in = S_INS_RD;
            else                      state_in = S_UPD_RD;
         end
         S_UPD_END: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      live_in  = live_ff;
      hole_in  = hole_ff;
      idc_in   = idc_ff;
      mind_in  = mind_ff;
      maxf_in  = maxf_ff;
      found_in = found_ff;
      retu_in  = retu_ff;
      new_in   = new_ff;
      now_in   = now_ff;
      tgt_in   = tgt_ff;
      nfire_in = nfire_ff;
      limit_in = limit_ff;
      pend_in  = pend_ff;
      pid_in   = pid_ff;
      rv_in    = 1'b0;
      rs_in    = rs_ff;
      rid_in   = rid_ff;
      rl_in    = rl_ff;
      we       = 1'b0;
      waddr    = hole_ff[AW-1:0];
      wdata    = new_ff;
      raddr    = hole_m1[AW-1:0];

      // register writes
      if (csr_wr) begin
         if (paddr[2] == REG_DELAY_FLOOR) mind_in = pwdata;
         else                             maxf_in = pwdata[6:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in = req_time_now;
               unique case (req_func)
                  FUNC_CREATE: begin
                     idc_in = idc_ff + 32'd1;
                     if (live_ff == CW'(SLOTS)) begin
                        rv_in = 1'b1; rs_in = ST_FULL; rid_in = '0; rl_in = 1'b1;
                     end else begin
                        new_in.id       = idc_ff + 32'd1;
                        new_in.deadline = sat_add48(req_time_now, to_eff);
                        new_in.period   = to_eff;
                        new_in.once     = req_one_shot;
                        hole_in         = live_ff;
                        retu_in         = 1'b0;
                     end
                  end
                  FUNC_REMOVE: begin
                     tgt_in = req_target_id;
                     if (req_target_id == 32'd0) begin
                        rv_in = 1'b1; rs_in = ST_REMOVED; rid_in = '0; rl_in = 1'b1;
                     end else begin
                        hole_in  = '0;
                        found_in = 1'b0;
                     end
                  end
                  FUNC_UPDATE: begin
                     nfire_in = '0;
                     pend_in  = 1'b0;
                     if (maxf_ff == 7'd0)             limit_in = 7'd1;
                     else if (maxf_ff > MAX_RESULTS)  limit_in = MAX_RESULTS;
                     else                             limit_in = maxf_ff;
                  end
                  default: ;
               endcase
            end
         end
         // hole at slot zero: drop the entry there, else read the entry below it
         S_INS_RD: begin
            if (hole_ff == '0) begin
               we      = 1'b1;
               live_in = live_ff + CW'(1);
               if (!retu_ff) begin
                  rv_in = 1'b1; rs_in = ST_CREATED; rid_in = new_ff.id; rl_in = 1'b1;
               end
            end
         end
         // later neighbor stops the slide, else move it up one slot
         S_INS_CHK: begin
            we = 1'b1;
            if (rd.deadline > new_ff.deadline) begin
               live_in = live_ff + CW'(1);
               if (!retu_ff) begin
                  rv_in = 1'b1; rs_in = ST_CREATED; rid_in = new_ff.id; rl_in = 1'b1;
               end
            end else begin
               wdata   = rd;
               hole_in = hole_m1;
            end
         end
         S_RM_RD: begin
            raddr = hole_ff[AW-1:0];
            if (hole_ff == live_ff) begin
               rv_in  = 1'b1;
               rl_in  = 1'b1;
               rs_in  = found_ff ? ST_REMOVED : ST_NOT_FOUND;
               rid_in = found_ff ? tgt_ff : 32'd0;
               if (found_ff) live_in = live_m1;
            end
         end
         // after a match, every entry shifts down one slot
         S_RM_CHK: begin
            if (found_ff) begin
               we    = 1'b1;
               waddr = hole_m1[AW-1:0];
               wdata = rd;
            end else if (rd.id == tgt_ff) begin
               found_in = 1'b1;
            end
            hole_in = hole_ff + CW'(1);
         end
         S_UPD_RD: begin
            raddr = live_m1[AW-1:0];
         end
         // top entry due: report the previous one, keep this one pending
         S_UPD_CHK: begin
            if (rd.deadline <= now_ff) begin
               if (pend_ff) begin
                  rv_in = 1'b1; rs_in = ST_FIRED; rid_in = pid_ff; rl_in = 1'b0;
               end
               pend_in  = 1'b1;
               pid_in   = rd.id;
               nfire_in = nfire_ff + 7'd1;
               live_in  = live_m1;
               new_in.id       = rd.id;
               new_in.deadline = sat_add48(rd.deadline, rd.period);
               new_in.period   = rd.period;
               new_in.once     = 1'b0;
               hole_in  = live_m1;
               retu_in  = 1'b1;
            end
         end
         S_UPD_END: begin
            rv_in  = 1'b1;
            rl_in  = 1'b1;
            rs_in  = pend_ff ? ST_FIRED : ST_NONE_DUE;
            rid_in = pend_ff ? pid_ff : 32'd0;
         end
         default: ;
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         live_ff  <= '0;
         idc_ff   <= '0;
         mind_ff  <= 32'd1;
         maxf_ff  <= MAX_RESULTS;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         retu_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         idc_ff   <= idc_in;
         mind_ff  <= mind_in;
         maxf_ff  <= maxf_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
         found_ff <= found_in;
         retu_ff  <= retu_in;
      end
      hole_ff  <= hole_in;
      new_ff   <= new_in;
      now_ff   <= now_in;
      tgt_ff   <= tgt_in;
      nfire_ff <= nfire_in;
      limit_ff <= limit_in;
      pid_ff   <= pid_in;
      rs_ff    <= rs_in;
      rid_ff   <= rid_in;
      rl_ff    <= rl_in;
   end

   assign rsp_valid    = rv_ff;
   assign rsp_status   = rs_ff;
   assign rsp_timer_id = rid_ff;
   assign rsp_last     = rl_ff;
   assign pready       = 1'b1;
   assign prdata       = (paddr[2] == REG_DELAY_FLOOR) ? mind_ff : {25'd0, maxf_ff};

   // checks
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CW'(SLOTS))
      else $error("live count above table size");

   a_upd_end_reports: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD_END |=> rsp_valid && rsp_last)
      else $error("update close gave no final item");

   a_create_inserts: assert property (@(posedge clock) disable iff (reset)
      accept && req_func == FUNC_CREATE && live_ff != CW'(SLOTS) |=> state_ff == S_INS_RD)
      else $error("create with room did not start insert");

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_UPD_CHK |-> nfire_ff < limit_ff)
      else $error("fired beyond limit");

endmodule

`default_nettype wire

// ===== rtl/core/stq_ram.sv =====
// ----------------------------------------------------------------------------
// stq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module stq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire
